// ===== hw/rtl/hrbsc_pkg.sv =====
// Shared types and constants for the heart-rate band speed controller.
// Used by hrbsc_ctrl, hrbsc_dp and the top level; no dependencies.
package hrbsc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 40;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] REG_CONTROL_ENABLE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TARGET_LOW     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TARGET_HIGH    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GAIN           = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DEADBAND       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_PERIOD_MS      = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_PWM_FLOOR      = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_PWM_CEILING    = 3'd7;

  localparam logic [7:0] VALID_MIN_BPM = 8'd40;
  localparam logic [7:0] VALID_MAX_BPM = 8'd200;
  localparam logic [7:0] ALPHA_KEEP    = 8'd154;
  localparam logic [7:0] ALPHA_NEW     = 8'd102;
  localparam logic [7:0] CHANGE_LIMIT  = 8'd255;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic avg_mul;
    logic avg_upd;
    logic ctrl;
    logic mul;
    logic upd;
    logic out_load;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic sample_ok;
    logic go;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/hrbsc_ctrl.sv =====
// Sequencer for the heart-rate band speed controller.
// Depends on hrbsc_pkg; drives the datapath through cmd_t, reads sts_t.
module hrbsc_ctrl
  import hrbsc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_AVGM = 3'd1;
  localparam logic [2:0] ST_AVGA = 3'd2;
  localparam logic [2:0] ST_CTRL = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt = ST_AVGM;
        end
      end
      ST_AVGM: begin
        // out-of-range samples change nothing, report right away
        if (sts.sample_ok) begin
          cmd.avg_mul = 1'b1;
          state_nxt = ST_AVGA;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_AVGA: begin
        cmd.avg_upd = 1'b1;
        state_nxt = ST_CTRL;
      end
      ST_CTRL: begin
        cmd.ctrl = 1'b1;
        state_nxt = sts.go ? ST_MUL : ST_DONE;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/hrbsc_dp.sv =====
// Datapath: config registers, average, band test, gain multiply, PWM update
// and the output register. Depends on hrbsc_pkg; sequenced by hrbsc_ctrl.
module hrbsc_dp
  import hrbsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wen,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,
  input  cmd_t                cmd,
  output sts_t                sts
);

  // configuration
  logic        enable_r;
  logic [7:0]  target_low_r;
  logic [7:0]  target_high_r;
  logic [7:0]  gain_r;
  logic [7:0]  deadband_r;
  logic [15:0] period_r;
  logic [7:0]  floor_r;
  logic [7:0]  ceiling_r;

  // block state
  logic [15:0] avg_r;
  logic [7:0]  drive_r;
  logic [31:0] last_r;

  // per-item working registers
  logic [7:0]        bpm_r;
  logic [31:0]       now_r;
  logic [23:0]       keep_r;
  logic [14:0]       newp_r;
  logic [15:0]       err_r;
  logic              neg_r;
  logic [23:0]       mprod_r;
  logic              adj_r;
  logic signed [8:0] change_r;

  logic              out_valid_r;
  logic [OutDataW-1:0] out_data_r;

  logic [15:0]       seed;
  logic [24:0]       avg_sum;
  logic [31:0]       elapsed;
  logic [16:0]       low_edge_cmp;
  logic [16:0]       high_edge;
  logic              below;
  logic              above;
  logic [24:0]       round_sum;
  logic [12:0]       mag;
  logic [7:0]        mag_sat;
  logic signed [8:0] chg;
  logic signed [9:0] next_lvl;
  logic [7:0]        drive_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b0;
      target_low_r  <= 8'd60;
      target_high_r <= 8'd70;
      gain_r        <= 8'd56;
      deadband_r    <= 8'd24;
      period_r      <= 16'd1000;
      floor_r       <= 8'd70;
      ceiling_r     <= 8'd255;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_CONTROL_ENABLE: enable_r      <= cfg_wdata[0];
        REG_TARGET_LOW:     target_low_r  <= cfg_wdata[7:0];
        REG_TARGET_HIGH:    target_high_r <= cfg_wdata[7:0];
        REG_GAIN:           gain_r        <= cfg_wdata[7:0];
        REG_DEADBAND:       deadband_r    <= cfg_wdata[7:0];
        REG_PERIOD_MS:      period_r      <= cfg_wdata;
        REG_PWM_FLOOR:      floor_r       <= cfg_wdata[7:0];
        REG_PWM_CEILING:    ceiling_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // zero average means not yet seeded
  assign seed = (avg_r == 16'd0) ? {bpm_r, 8'h00} : avg_r;
  assign avg_sum = {1'b0, keep_r} + {2'b00, newp_r, 8'h00} + 25'd128;

  assign elapsed = now_r - last_r;
  assign low_edge_cmp = {1'b0, avg_r} + {5'b0, deadband_r, 4'h0};
  assign high_edge = {1'b0, target_high_r, 8'h00} + {5'b0, deadband_r, 4'h0};
  assign below = low_edge_cmp < {1'b0, target_low_r, 8'h00};
  assign above = {1'b0, avg_r} > high_edge;

  // round half away from zero on the magnitude, then saturate
  assign round_sum = {1'b0, mprod_r} + 25'd2048;
  assign mag = round_sum[24:12];
  assign mag_sat = (mag > {5'b0, CHANGE_LIMIT}) ? CHANGE_LIMIT : mag[7:0];
  assign chg = neg_r ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});
  assign next_lvl = $signed({2'b00, drive_r}) + 10'(chg);

  always_comb begin
    if (next_lvl < $signed({2'b00, floor_r})) begin
      drive_nxt = floor_r;
    end else if (next_lvl > $signed({2'b00, ceiling_r})) begin
      drive_nxt = ceiling_r;
    end else begin
      drive_nxt = next_lvl[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r   <= 16'd0;
      drive_r <= 8'd70;
      last_r  <= 32'd0;
    end else begin
      if (cmd.avg_upd) begin
        avg_r <= avg_sum[23:8];
      end
      if (cmd.ctrl && sts.go) begin
        last_r <= now_r;
      end
      if (cmd.upd) begin
        drive_r <= drive_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      bpm_r    <= in_tdata[7:0];
      now_r    <= in_tdata[39:8];
      adj_r    <= 1'b0;
      change_r <= '0;
    end
    if (cmd.avg_mul) begin
      keep_r <= 24'(seed * ALPHA_KEEP);
      newp_r <= 15'(bpm_r * ALPHA_NEW);
    end
    if (cmd.ctrl) begin
      adj_r <= sts.go;
      if (below) begin
        err_r <= {target_low_r, 8'h00} - avg_r;
        neg_r <= 1'b0;
      end else if (above) begin
        err_r <= avg_r - {target_high_r, 8'h00};
        neg_r <= 1'b1;
      end else begin
        err_r <= 16'd0;
        neg_r <= 1'b0;
      end
    end
    if (cmd.mul) begin
      mprod_r <= 24'(gain_r * err_r);
    end
    if (cmd.upd) begin
      change_r <= chg;
    end
    if (cmd.out_load) begin
      // pwm, average, valid, adjusted, change, zero pad
      out_data_r <= {5'b0, change_r, adj_r, sts.sample_ok, avg_r, drive_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.sample_ok = (bpm_r >= VALID_MIN_BPM) && (bpm_r <= VALID_MAX_BPM);
  assign sts.go = enable_r && (elapsed >= {16'd0, period_r});
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

endmodule

// ===== hw/rtl/heart_rate_band_speed_controller.sv =====
// Heart-rate band speed controller, top level: sequencer plus datapath.
// States from accept to result: AVGM, DONE for an out-of-range sample; AVGM, AVGA,
// CTRL, DONE with control off or period not elapsed; AVGM, AVGA, CTRL, MUL, UPD,
// DONE when the PWM is adjusted. One item at a time; DONE waits for a free output.
// Reset (rst_n low, synchronous) loads register defaults, clears the average
// and timer, sets the PWM to 70 and empties the output register.
module heart_rate_band_speed_controller
  import hrbsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wen,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // sample_bpm[7:0], now_ms[39:8]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata   // pwm_level[7:0], smoothed_bpm[23:8],
                                          // sample_valid[24], adjusted[25],
                                          // pwm_change[34:26], zeros above
);

  cmd_t cmd;
  sts_t sts;

  hrbsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hrbsc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ===== hw/rtl/hrbsc_checker.sv =====
// Port-level checks for the heart-rate band speed controller.
// Depends on hrbsc_pkg; bound to the top level below.
module hrbsc_checker
  import hrbsc_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata
);

  // a waiting result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while busy");

  // invalid samples never adjust and report no change
  a_invalid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[24] |-> !out_tdata[25] && (out_tdata[34:26] == 9'd0))
    else $error("invalid sample adjusted");

  // no change reported without an adjustment
  a_change_needs_adj: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[25] |-> out_tdata[34:26] == 9'd0)
    else $error("change without adjustment");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind heart_rate_band_speed_controller hrbsc_checker u_hrbsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
